/* hdl/gte_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Geodetic to ECEF conversion package
// Shared widths, fixed-point constants and pipeline depths of the converter.
// ----------------------------------------------------------------------------
package gte_pkg;

  localparam int ANGLE_BITS = 32;
  localparam logic [63:0] ANGLE_MASK = ~((64'd1 << (64 - ANGLE_BITS)) - 64'd1);

  localparam int AXIS_W = 34;
  localparam int OUT_W  = 40;

  localparam logic [60:0] HALF_PI_Q60 = 61'h1921FB54442D1847;
  localparam logic [60:0] ONE_Q60     = 61'd1 << 60;

  localparam int TERMS      = 12;
  localparam int SC_LAT     = 4 * TERMS + 6;
  localparam int SQRT_STEPS = 63;
  localparam int DIV_STEPS  = 61;
  localparam int UV_DLY     = SQRT_STEPS + 2;
  localparam int MID_LAT    = 5 + SQRT_STEPS + DIV_STEPS;
  localparam int LATENCY    = SC_LAT + MID_LAT + 5;

  localparam logic [AXIS_W-1:0] MAJOR_RESET = 34'd6378137000;
  localparam logic [AXIS_W-1:0] MINOR_RESET = 34'd6356752314;

  typedef enum logic [0:0] {
    REG_MAJOR = 1'b0,
    REG_MINOR = 1'b1
  } reg_idx_e;

  typedef logic signed [61:0] trig_t;
  typedef logic [AXIS_W-1:0]  axis_t;

  // A 64 by 64 product split into four 32 by 32 partial products, which are
  // registered before they are summed in the following stage.
  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
  } pp_t;

  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.hh = 64'(a[63:32]) * 64'(b[63:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.lh = 64'(a[31:0]) * 64'(b[63:32]);
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    return p;
  endfunction

  function automatic logic [127:0] pp_sum(input pp_t p);
    return {p.hh, p.ll} + {31'd0, 65'(p.hl) + 65'(p.lh), 32'd0};
  endfunction

endpackage

/* hdl/gte_sincos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined sine and cosine
// Octant reduction, then four stages per series term, then quadrant mapping.
// ----------------------------------------------------------------------------
module gte_sincos (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [31:0]   angle_i,
  output logic          valid_o,
  output gte_pkg::trig_t sin_o,
  output gte_pkg::trig_t cos_o
);
  import gte_pkg::*;

  typedef struct packed {
    logic [1:0]  quad;
    logic        swap;
    logic [60:0] th2;
    logic [60:0] st;
    logic [60:0] ct;
    logic [60:0] sterm;
    logic [60:0] cterm;
  } sc_stage_t;

  typedef struct packed {
    logic [1:0] quad;
    logic       swap;
  } oct_t;

  logic [63:0]  turn;
  logic         swap_d;
  logic [62:0]  red;
  logic [127:0] th_sum, th2_sum;

  oct_t        oct_q [0:3];
  logic [61:0] red_q;
  pp_t         th_pp_q;
  logic [60:0] th_q;
  pp_t         th2_pp_q;
  logic [60:0] th_dly_q;

  sc_stage_t   stage_q [0:TERMS];
  logic [SC_LAT-1:0] vld_q;

  logic [60:0] sq, cq;
  trig_t       sin_d, cos_d;

  always_comb begin
    turn    = {angle_i, 32'd0} & ANGLE_MASK;
    swap_d  = turn[61:0] > (62'd1 << 61);
    red     = swap_d ? ((63'd1 << 62) - {1'b0, turn[61:0]}) : {1'b0, turn[61:0]};
    th_sum  = pp_sum(th_pp_q);
    th2_sum = pp_sum(th2_pp_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[SC_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    oct_q[0] <= '{quad: turn[63:62], swap: swap_d};
    red_q    <= red[61:0];
    for (int i = 1; i < 4; i++) begin
      oct_q[i] <= oct_q[i-1];
    end
    th_pp_q  <= pp_mul(64'(red_q), 64'(HALF_PI_Q60));
    th_q     <= th_sum[122:62];
    th2_pp_q <= pp_mul(64'(th_q), 64'(th_q));
    th_dly_q <= th_q;
    stage_q[0].quad  <= oct_q[3].quad;
    stage_q[0].swap  <= oct_q[3].swap;
    stage_q[0].th2   <= th2_sum[120:60];
    stage_q[0].st    <= th_dly_q;
    stage_q[0].sterm <= th_dly_q;
    stage_q[0].ct    <= ONE_Q60;
    stage_q[0].cterm <= ONE_Q60;
  end

  for (genvar k = 0; k < TERMS; k++) begin : g_term
    localparam int SinDiv = (2 * (k + 1)) * (2 * (k + 1) + 1);
    localparam int CosDiv = (2 * (k + 1) - 1) * (2 * (k + 1));
    localparam int SinSh  = 60 + $clog2(SinDiv);
    localparam int CosSh  = 60 + $clog2(CosDiv);
    localparam logic [63:0] SinRcp =
      64'(((128'd1 << SinSh) + 128'(SinDiv - 1)) / 128'(SinDiv));
    localparam logic [63:0] CosRcp =
      64'(((128'd1 << CosSh) + 128'(CosDiv - 1)) / 128'(CosDiv));
    sc_stage_t    a_q, b_q, c_q, nxt;
    pp_t          ps_q, pc_q, rs_q, rc_q;
    logic [59:0]  xs_q, xc_q;
    logic [127:0] ms, mc, qs, qc;
    logic [60:0]  ts, tc;

    always_comb begin
      ms  = pp_sum(ps_q);
      mc  = pp_sum(pc_q);
      qs  = pp_sum(rs_q);
      qc  = pp_sum(rc_q);
      ts  = 61'(qs >> SinSh);
      tc  = 61'(qc >> CosSh);
      nxt = c_q;
      nxt.sterm = ts;
      nxt.cterm = tc;
      if ((k % 2) == 0) begin
        nxt.st = c_q.st - ts;
        nxt.ct = c_q.ct - tc;
      end else begin
        nxt.st = c_q.st + ts;
        nxt.ct = c_q.ct + tc;
      end
    end

    always_ff @(posedge clk_i) begin
      a_q  <= stage_q[k];
      ps_q <= pp_mul(64'(stage_q[k].sterm), 64'(stage_q[k].th2));
      pc_q <= pp_mul(64'(stage_q[k].cterm), 64'(stage_q[k].th2));
      b_q  <= a_q;
      xs_q <= ms[119:60];
      xc_q <= mc[119:60];
      c_q  <= b_q;
      rs_q <= pp_mul(64'(xs_q), SinRcp);
      rc_q <= pp_mul(64'(xc_q), CosRcp);
      stage_q[k+1] <= nxt;
    end
  end

  always_comb begin
    sq = stage_q[TERMS].swap ? stage_q[TERMS].ct : stage_q[TERMS].st;
    cq = stage_q[TERMS].swap ? stage_q[TERMS].st : stage_q[TERMS].ct;
    case (stage_q[TERMS].quad)
      2'd0: begin
        sin_d = trig_t'({1'b0, sq});
        cos_d = trig_t'({1'b0, cq});
      end
      2'd1: begin
        sin_d = trig_t'({1'b0, cq});
        cos_d = -trig_t'({1'b0, sq});
      end
      2'd2: begin
        sin_d = -trig_t'({1'b0, sq});
        cos_d = -trig_t'({1'b0, cq});
      end
      default: begin
        sin_d = -trig_t'({1'b0, cq});
        cos_d = trig_t'({1'b0, sq});
      end
    endcase
  end

  assign valid_o = vld_q[SC_LAT-1];

  always_ff @(posedge clk_i) begin
    sin_o <= sin_d;
    cos_o <= cos_d;
  end

endmodule

/* hdl/gte_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit root of a 125-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module gte_isqrt (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [124:0] rad_i,
  output logic         valid_o,
  output logic [62:0]  root_o
);
  import gte_pkg::*;

  typedef struct packed {
    logic [125:0] rad;
    logic [65:0]  rem;
    logic [62:0]  root;
  } sq_stage_t;

  sq_stage_t sq_q  [0:SQRT_STEPS-1];
  logic      vld_q [0:SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    sq_stage_t cur, nxt;
    logic      vin;
    logic [65:0] r2, trial;
    logic        ge;

    always_comb begin
      if (k == 0) begin
        cur.rad  = {1'b0, rad_i};
        cur.rem  = '0;
        cur.root = '0;
        vin      = valid_i;
      end else begin
        cur = sq_q[(k == 0) ? 0 : k - 1];
        vin = vld_q[(k == 0) ? 0 : k - 1];
      end
      r2       = {cur.rem[63:0], cur.rad[125:124]};
      trial    = {1'b0, cur.root, 2'b01};
      ge       = r2 >= trial;
      nxt.rad  = {cur.rad[123:0], 2'b00};
      nxt.rem  = ge ? (r2 - trial) : r2;
      nxt.root = {cur.root[61:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[k] <= nxt;
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign root_o  = sq_q[SQRT_STEPS-1].root;

endmodule

/* hdl/gte_ratio.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined ratio divider
// Forms u/D and v/D in Q60 with two restoring dividers, one bit per stage.
// ----------------------------------------------------------------------------
module gte_ratio (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [61:0] u_i,
  input  logic [61:0] v_i,
  input  logic [62:0] d_i,
  output logic        valid_o,
  output logic [60:0] rc_o,
  output logic [60:0] rs_o
);
  import gte_pkg::*;

  typedef struct packed {
    logic [62:0] d;
    logic        dz;
    logic [62:0] remc;
    logic [62:0] rems;
    logic [60:0] qc;
    logic [60:0] qs;
  } div_stage_t;

  div_stage_t dv_q  [0:DIV_STEPS-1];
  logic       vld_q [0:DIV_STEPS-1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    div_stage_t cur, nxt;
    logic       vin;
    logic [63:0] c2, s2;
    logic        gec, ges;

    always_comb begin
      cur = dv_q[(k == 0) ? 0 : k - 1];
      vin = vld_q[(k == 0) ? 0 : k - 1];
      nxt = cur;
      c2  = '0;
      s2  = '0;
      if (k == 0) begin
        vin      = valid_i;
        gec      = {1'b0, u_i} >= d_i;
        ges      = {1'b0, v_i} >= d_i;
        nxt.d    = d_i;
        nxt.dz   = d_i == '0;
        nxt.remc = {1'b0, u_i} - (gec ? d_i : 63'd0);
        nxt.rems = {1'b0, v_i} - (ges ? d_i : 63'd0);
        nxt.qc   = {60'd0, gec};
        nxt.qs   = {60'd0, ges};
      end else begin
        c2       = {cur.remc, 1'b0};
        s2       = {cur.rems, 1'b0};
        gec      = c2 >= {1'b0, cur.d};
        ges      = s2 >= {1'b0, cur.d};
        nxt.remc = gec ? 63'(c2 - {1'b0, cur.d}) : c2[62:0];
        nxt.rems = ges ? 63'(s2 - {1'b0, cur.d}) : s2[62:0];
        nxt.qc   = {cur.qc[59:0], gec};
        nxt.qs   = {cur.qs[59:0], ges};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k] <= nxt;
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign rc_o    = dv_q[DIV_STEPS-1].dz ? 61'd0 : dv_q[DIV_STEPS-1].qc;
  assign rs_o    = dv_q[DIV_STEPS-1].dz ? 61'd0 : dv_q[DIV_STEPS-1].qs;

endmodule

/* hdl/geodetic_to_ecef_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Geodetic to ECEF converter
// Converts latitude, longitude and height to earth-centred X, Y and Z in mm.
// ----------------------------------------------------------------------------
// A request is taken at every clock edge with start_i high; busy_o stays low,
// so one point enters in every cycle. Each result appears on x_mm_o, y_mm_o,
// z_mm_o and last_point_out_o for exactly one cycle with done_o high, in
// request order. Each request passes through the 54-stage sine and cosine
// pipeline, the 63-stage square root, the 61-stage divider and ten multiply,
// scaling and rounding stages.
// The ellipsoid axes sit in an APB register file: semi-major axis at byte
// address 0, semi-minor axis at address 8, 34 bits each in a 64-bit word.
// The axes should change only while no request is in flight.
// Reset clears every valid bit in the pipeline and restores the WGS84 axes.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module geodetic_to_ecef_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [31:0]  latitude_angle_i,
  input  logic signed [31:0]  longitude_angle_i,
  input  logic signed [31:0]  height_mm_i,
  input  logic                last_point_in_i,
  output logic                done_o,
  output logic signed [39:0]  x_mm_o,
  output logic signed [39:0]  y_mm_o,
  output logic signed [39:0]  z_mm_o,
  output logic                last_point_out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import gte_pkg::*;

  typedef struct packed {
    logic signed [31:0] h;
    logic               last;
  } pre_t;

  typedef struct packed {
    logic signed [31:0] h;
    trig_t              c;
    trig_t              s;
    trig_t              cl;
    trig_t              sl;
    logic               last;
  } side_t;

  function automatic logic signed [39:0] round_sat(input logic signed [55:0] v);
    logic [55:0] m;
    logic [40:0] r;
    m = v[55] ? (~v + 56'sd1) : v;
    r = 41'((m + 56'h8000) >> 16);
    if (v[55]) begin
      if (r > 41'd549755813888) begin
        r = 41'd549755813888;
      end
      return 40'(-r);
    end else begin
      if (r > 41'd549755813887) begin
        r = 41'd549755813887;
      end
      return 40'(r);
    end
  endfunction

  axis_t a_q, b_q;
  logic  wr_en;

  pre_t  pre_q  [0:SC_LAT-1];
  side_t side_q [0:MID_LAT-1];
  logic [123:0] uv_q [0:UV_DLY-1];

  logic  trig_vld, lon_vld;
  trig_t s_lat, c_lat, s_lon, c_lon;
  side_t side_d;

  logic [60:0] c_mag, s_mag;
  pp_t         ppu_q, ppv_q;
  logic        vA1_q_vld;
  logic [94:0] uA_q, vA_q;
  logic        vA_q_vld;
  logic [94:0] uv_or;
  logic [6:0]  nbits;
  logic [5:0]  sh;
  logic [61:0] uB_q, vB_q;
  logic        vB_q_vld;
  pp_t         ppuu_q, ppvv_q;
  logic        vC1_q_vld;
  logic [124:0] d2C_q;
  logic         vC_q_vld;

  logic        sq_vld;
  logic [62:0] d_root;
  logic        rt_vld;
  logic [60:0] rc, rs;

  side_t       sd;
  logic [31:0] h_mag;
  logic [60:0] hc_mag, hs_mag;
  pp_t         ppa_q, ppb_q, pphc_q, pphs_q;
  side_t       sdE_q;
  logic        vE1_q;
  logic [94:0] pf_p, qf_p;
  logic [92:0] hc_p, hs_p;
  logic signed [53:0] e_d, f_d;
  logic signed [53:0] e_q, f_q;
  trig_t       clE_q, slE_q;
  logic        lastE_q, vE_q;

  logic [53:0]  e_mag;
  logic [60:0]  cl_mag, sl_mag;
  pp_t          ppx_q, ppy_q;
  logic         xneg_q, yneg_q;
  logic signed [53:0] fF1_q;
  logic         lastF1_q, vF1_q;
  logic [114:0] xp, yp;
  logic signed [55:0] x_d, y_d;
  logic signed [55:0] x_q, y_q, fF_q;
  logic        lastF_q, vF_q;

  assign busy_o = 1'b0;
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= MAJOR_RESET;
      b_q <= MINOR_RESET;
    end else if (wr_en) begin
      case (reg_idx_e'(paddr[3]))
        REG_MAJOR: a_q <= pwdata[AXIS_W-1:0];
        REG_MINOR: b_q <= pwdata[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr[3]))
      REG_MAJOR: prdata = 64'(a_q);
      REG_MINOR: prdata = 64'(b_q);
      default:   prdata = '0;
    endcase
  end

  gte_sincos u_lat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .angle_i (latitude_angle_i),
    .valid_o (trig_vld),
    .sin_o   (s_lat),
    .cos_o   (c_lat)
  );

  gte_sincos u_lon (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .angle_i (longitude_angle_i),
    .valid_o (lon_vld),
    .sin_o   (s_lon),
    .cos_o   (c_lon)
  );

  always_ff @(posedge clk_i) begin
    pre_q[0] <= '{h: height_mm_i, last: last_point_in_i};
    for (int i = 1; i < SC_LAT; i++) begin
      pre_q[i] <= pre_q[i-1];
    end
  end

  always_comb begin
    side_d.h    = pre_q[SC_LAT-1].h;
    side_d.last = pre_q[SC_LAT-1].last;
    side_d.c    = c_lat;
    side_d.s    = s_lat;
    side_d.cl   = c_lon;
    side_d.sl   = s_lon;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < MID_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
    uv_q[0] <= {uB_q, vB_q};
    for (int i = 1; i < UV_DLY; i++) begin
      uv_q[i] <= uv_q[i-1];
    end
  end

  always_comb begin
    c_mag = c_lat[61] ? 61'(-c_lat) : c_lat[60:0];
    s_mag = s_lat[61] ? 61'(-s_lat) : s_lat[60:0];
    uv_or = uA_q | vA_q;
    nbits = '0;
    for (int i = 0; i < 95; i++) begin
      if (uv_or[i]) begin
        nbits = 7'(i + 1);
      end
    end
    sh = (nbits > 7'd62) ? 6'(nbits - 7'd62) : 6'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vA1_q_vld <= 1'b0;
      vA_q_vld  <= 1'b0;
      vB_q_vld  <= 1'b0;
      vC1_q_vld <= 1'b0;
      vC_q_vld  <= 1'b0;
    end else begin
      vA1_q_vld <= trig_vld & lon_vld;
      vA_q_vld  <= vA1_q_vld;
      vB_q_vld  <= vA_q_vld;
      vC1_q_vld <= vB_q_vld;
      vC_q_vld  <= vC1_q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ppu_q  <= pp_mul(64'(a_q), 64'(c_mag));
    ppv_q  <= pp_mul(64'(b_q), 64'(s_mag));
    uA_q   <= 95'(pp_sum(ppu_q));
    vA_q   <= 95'(pp_sum(ppv_q));
    uB_q   <= 62'(uA_q >> sh);
    vB_q   <= 62'(vA_q >> sh);
    ppuu_q <= pp_mul(64'(uB_q), 64'(uB_q));
    ppvv_q <= pp_mul(64'(vB_q), 64'(vB_q));
    d2C_q  <= 125'(pp_sum(ppuu_q) + pp_sum(ppvv_q));
  end

  gte_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vC_q_vld),
    .rad_i   (d2C_q),
    .valid_o (sq_vld),
    .root_o  (d_root)
  );

  gte_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .u_i     (uv_q[UV_DLY-1][123:62]),
    .v_i     (uv_q[UV_DLY-1][61:0]),
    .d_i     (d_root),
    .valid_o (rt_vld),
    .rc_o    (rc),
    .rs_o    (rs)
  );

  always_comb begin
    sd     = side_q[MID_LAT-1];
    h_mag  = sd.h[31] ? 32'(-sd.h) : sd.h;
    hc_mag = sd.c[61] ? 61'(-sd.c) : sd.c[60:0];
    hs_mag = sd.s[61] ? 61'(-sd.s) : sd.s[60:0];
  end

  always_comb begin
    pf_p   = 95'(pp_sum(ppa_q));
    qf_p   = 95'(pp_sum(ppb_q));
    hc_p   = 93'(pp_sum(pphc_q));
    hs_p   = 93'(pp_sum(pphs_q));
    e_d    = (sdE_q.c[61] ? -$signed(54'(pf_p[94:44])) : $signed(54'(pf_p[94:44])))
           + ((sdE_q.h[31] != sdE_q.c[61]) ? -$signed(54'(hc_p[92:44]))
                                           : $signed(54'(hc_p[92:44])));
    f_d    = (sdE_q.s[61] ? -$signed(54'(qf_p[94:44])) : $signed(54'(qf_p[94:44])))
           + ((sdE_q.h[31] != sdE_q.s[61]) ? -$signed(54'(hs_p[92:44]))
                                           : $signed(54'(hs_p[92:44])));
  end

  always_comb begin
    e_mag  = e_q[53] ? 54'(-e_q) : e_q;
    cl_mag = clE_q[61] ? 61'(-clE_q) : clE_q[60:0];
    sl_mag = slE_q[61] ? 61'(-slE_q) : slE_q[60:0];
    xp     = 115'(pp_sum(ppx_q));
    yp     = 115'(pp_sum(ppy_q));
    x_d    = xneg_q ? -$signed(56'(xp[114:60])) : $signed(56'(xp[114:60]));
    y_d    = yneg_q ? -$signed(56'(yp[114:60])) : $signed(56'(yp[114:60]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vE1_q  <= 1'b0;
      vE_q   <= 1'b0;
      vF1_q  <= 1'b0;
      vF_q   <= 1'b0;
      done_o <= 1'b0;
    end else begin
      vE1_q  <= rt_vld;
      vE_q   <= vE1_q;
      vF1_q  <= vE_q;
      vF_q   <= vF1_q;
      done_o <= vF_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ppa_q    <= pp_mul(64'(a_q), 64'(rc));
    ppb_q    <= pp_mul(64'(b_q), 64'(rs));
    pphc_q   <= pp_mul(64'(h_mag), 64'(hc_mag));
    pphs_q   <= pp_mul(64'(h_mag), 64'(hs_mag));
    sdE_q    <= sd;
    e_q      <= e_d;
    f_q      <= f_d;
    clE_q    <= sdE_q.cl;
    slE_q    <= sdE_q.sl;
    lastE_q  <= sdE_q.last;
    ppx_q    <= pp_mul(64'(e_mag), 64'(cl_mag));
    ppy_q    <= pp_mul(64'(e_mag), 64'(sl_mag));
    xneg_q   <= e_q[53] != clE_q[61];
    yneg_q   <= e_q[53] != slE_q[61];
    fF1_q    <= f_q;
    lastF1_q <= lastE_q;
    x_q      <= x_d;
    y_q      <= y_d;
    fF_q     <= 56'(fF1_q);
    lastF_q  <= lastF1_q;
    x_mm_o   <= round_sat(x_q);
    y_mm_o   <= round_sat(y_q);
    z_mm_o   <= round_sat(fF_q);
    last_point_out_o <= lastF_q;
  end

endmodule

/* hdl/gte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Geodetic to ECEF port checker
// Watches the converter ports for timing and pass-through properties.
// ----------------------------------------------------------------------------
module gte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [31:0] latitude_angle_i,
  input logic               last_point_in_i,
  input logic               done_o,
  input logic signed [39:0] z_mm_o,
  input logic               last_point_out_o
);
  import gte_pkg::*;

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("converter refused a request");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY done_o)
    else $error("request produced no result at the expected cycle");

  a_no_extra : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching request");

  a_last_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (last_point_out_o == $past(last_point_in_i, LATENCY)))
    else $error("last marker not carried through");

  a_equator_z : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(latitude_angle_i == 32'sd0, LATENCY)) |-> (z_mm_o == 40'sd0))
    else $error("nonzero Z on the equator");

endmodule

bind geodetic_to_ecef_core gte_checker u_gte_checker (.*);
